// File: hdl/ping_pong_playback_buffer_control_macros.svh
// Assertion macros used by the controller RTL.
`ifndef PING_PONG_PLAYBACK_BUFFER_CONTROL_MACROS_SVH
`define PING_PONG_PLAYBACK_BUFFER_CONTROL_MACROS_SVH

`ifndef NO_ASSERTIONS

// Consequent must hold in the same cycle as the antecedent.
`define PPBC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define PPBC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define PPBC_ASSERT_NOW(label, clk, rst, ante, cons)
`define PPBC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: hdl/ppbc_pkg.sv
package ppbc_pkg;

  typedef enum logic [1:0] {
    CMD_SUBMIT    = 2'd0,
    CMD_HALF_DONE = 2'd1,
    CMD_STOP      = 2'd2,
    CMD_POLL      = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_DEVICE = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_BUSY      = 2'd3
  } status_t;

  localparam logic [15:0] RATE_MIN = 16'd4000;
  localparam logic [15:0] RATE_MAX = 16'd44100;

  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] byte_count;
    logic [15:0] rate_hz;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic        write_half;
    logic [14:0] pad_count;
    logic        silence_fill;
    logic        silent_half;
    logic        stream_start;
    logic [15:0] start_rate;
    logic        halted;
    logic        is_playing;
    logic        can_queue;
  } rsp_t;

endpackage

// File: hdl/ping_pong_playback_buffer_control.sv
// Control for a two-half ping-pong playback buffer. Each request item is one
// event (submit, half played, stop, poll) and produces exactly one response
// item. The block takes one item per cycle while requests are not stalled: an
// item is held in an input stage register, and the whole state update runs in
// a single pass of flag logic between that stage and the response register,
// which loads the response as the item leaves the stage. The stage lets one
// more item in while a response is stalled; requests stall only while the
// stage is occupied and the response register holds a stalled item. The user
// must write device_present through cfg_we/cfg_wdata only while no events are
// in flight; the block itself does not enforce this.
`include "ping_pong_playback_buffer_control_macros.svh"

module ping_pong_playback_buffer_control #(
  parameter int HALF_BYTES     = 32768,
  parameter int UNDERRUN_LIMIT = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic            cfg_wdata,
  input  logic            req_valid,
  output logic            req_stall,
  input  ppbc_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output ppbc_pkg::rsp_t  rsp
);

  localparam logic [16:0] HALF      = 17'(HALF_BYTES);
  localparam logic [1:0]  UR_LIMIT  = 2'(UNDERRUN_LIMIT);

  // Configuration
  logic device_present;

  // Input stage
  logic           stage_valid;
  ppbc_pkg::req_t stage;
  logic           advance;

  // Controller state
  logic        stream_playing, stream_playing_next;
  logic        primed, primed_next;
  logic [1:0]  half_full, half_full_next;
  logic        playing_half, playing_half_next;
  logic        next_fill_half, next_fill_half_next;
  logic [1:0]  underrun_count, underrun_count_next;
  logic [15:0] stream_rate, stream_rate_next;

  ppbc_pkg::rsp_t result;

  // Advance the stage unless the response register is full and stalled.
  assign advance   = stage_valid && !(rsp_valid && rsp_stall);
  assign req_stall = stage_valid && rsp_valid && rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_present <= 1'b0;
    end else if (cfg_we) begin
      device_present <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (req_valid && !req_stall) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      stage <= req;
    end
  end

  // Single-pass event handling, written in the order the event is resolved.
  always_comb begin
    logic [15:0] rate_sat;
    logic [16:0] bytes_ext;
    logic [16:0] bytes_clamped;
    logic [16:0] pad_ext;
    logic        wrote;

    stream_playing_next = stream_playing;
    primed_next         = primed;
    half_full_next      = half_full;
    playing_half_next   = playing_half;
    next_fill_half_next = next_fill_half;
    underrun_count_next = underrun_count;
    stream_rate_next    = stream_rate;
    result              = '0;
    wrote               = 1'b0;

    // Saturate the rate and clamp the count to one half.
    if (stage.rate_hz < ppbc_pkg::RATE_MIN) begin
      rate_sat = ppbc_pkg::RATE_MIN;
    end else if (stage.rate_hz > ppbc_pkg::RATE_MAX) begin
      rate_sat = ppbc_pkg::RATE_MAX;
    end else begin
      rate_sat = stage.rate_hz;
    end
    bytes_ext     = {1'b0, stage.byte_count};
    bytes_clamped = (bytes_ext > HALF) ? HALF : bytes_ext;
    pad_ext       = HALF - bytes_clamped;

    unique case (stage.cmd)
      ppbc_pkg::CMD_SUBMIT: begin
        if (!device_present) begin
          result.status = ppbc_pkg::ST_NO_DEVICE;
        end else if (stage.byte_count == 16'd0) begin
          result.status = ppbc_pkg::ST_EMPTY;
        end else begin
          // A new rate while running: halt first, then prime afresh.
          if (stream_playing_next && (stream_rate_next != rate_sat)) begin
            stream_playing_next = 1'b0;
            primed_next         = 1'b0;
            half_full_next      = 2'b00;
            underrun_count_next = 2'd0;
            result.halted       = 1'b1;
          end
          if (!stream_playing_next && !primed_next) begin
            // Prime half 0 and store the rate.
            half_full_next      = 2'b01;
            next_fill_half_next = 1'b1;
            stream_rate_next    = rate_sat;
            primed_next         = 1'b1;
            result.write_half   = 1'b0;
            wrote               = 1'b1;
          end else if (primed_next && !stream_playing_next) begin
            // Fill half 1 and start at the primed rate.
            result.write_half   = 1'b1;
            wrote               = 1'b1;
            half_full_next[1]   = 1'b1;
            next_fill_half_next = 1'b0;
            primed_next         = 1'b0;
            stream_playing_next = 1'b1;
            playing_half_next   = 1'b0;
            underrun_count_next = 2'd0;
            result.stream_start = 1'b1;
          end else if (half_full_next[next_fill_half_next]) begin
            result.status = ppbc_pkg::ST_BUSY;
          end else begin
            result.write_half                   = next_fill_half_next;
            half_full_next[next_fill_half_next] = 1'b1;
            next_fill_half_next                 = !next_fill_half_next;
            underrun_count_next                 = 2'd0;
            wrote                               = 1'b1;
          end
          if (wrote) begin
            result.pad_count = pad_ext[14:0];
          end
        end
      end
      ppbc_pkg::CMD_HALF_DONE: begin
        if (stream_playing) begin
          // Release the finished half and flip to the other one.
          half_full_next[playing_half] = 1'b0;
          playing_half_next            = !playing_half;
          next_fill_half_next          = playing_half;
          if (!half_full_next[playing_half_next]) begin
            // Underrun: ask for silence in the half now playing.
            result.silence_fill               = 1'b1;
            result.silent_half                = playing_half_next;
            half_full_next[playing_half_next] = 1'b1;
            if (underrun_count_next != 2'd3) begin
              underrun_count_next = underrun_count_next + 2'd1;
            end
            if (underrun_count_next >= UR_LIMIT) begin
              stream_playing_next = 1'b0;
              primed_next         = 1'b0;
              half_full_next      = 2'b00;
              underrun_count_next = 2'd0;
              result.halted       = 1'b1;
            end
          end else begin
            underrun_count_next = 2'd0;
          end
        end
      end
      ppbc_pkg::CMD_STOP: begin
        if (device_present) begin
          stream_playing_next = 1'b0;
          primed_next         = 1'b0;
          half_full_next      = 2'b00;
          underrun_count_next = 2'd0;
          result.halted       = 1'b1;
        end
      end
      ppbc_pkg::CMD_POLL: begin
        if (primed && !stream_playing) begin
          half_full_next[1]   = 1'b1;
          next_fill_half_next = 1'b0;
          primed_next         = 1'b0;
          stream_playing_next = 1'b1;
          playing_half_next   = 1'b0;
          underrun_count_next = 2'd0;
          result.stream_start = 1'b1;
        end
      end
    endcase

    result.start_rate = stream_rate_next;
    result.is_playing = stream_playing_next;
    if (!device_present) begin
      result.can_queue = 1'b0;
    end else if (!stream_playing_next) begin
      result.can_queue = 1'b1;
    end else begin
      result.can_queue = !half_full_next[next_fill_half_next];
    end
  end

  // Commit state as the item leaves the stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      stream_playing <= 1'b0;
      primed         <= 1'b0;
      half_full      <= 2'b00;
      playing_half   <= 1'b0;
      next_fill_half <= 1'b0;
      underrun_count <= 2'd0;
      stream_rate    <= 16'd0;
    end else if (advance) begin
      stream_playing <= stream_playing_next;
      primed         <= primed_next;
      half_full      <= half_full_next;
      playing_half   <= playing_half_next;
      next_fill_half <= next_fill_half_next;
      underrun_count <= underrun_count_next;
      stream_rate    <= stream_rate_next;
    end
  end

  // Response register: load on advance, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= result;
    end
  end

  `PPBC_ASSERT_NOW(a_idle_halves_empty, clk, rst, !stream_playing && !primed, half_full == 2'b00)
  `PPBC_ASSERT_NOW(a_primed_not_playing, clk, rst, primed, !stream_playing)
  `PPBC_ASSERT_NOW(a_start_plays, clk, rst, rsp_valid && rsp.stream_start, rsp.is_playing)
  `PPBC_ASSERT_NOW(a_halt_stops, clk, rst, rsp_valid && rsp.halted, !rsp.is_playing)
  `PPBC_ASSERT_NEXT(a_advance_loads, clk, rst, advance, rsp_valid && rsp.start_rate == stream_rate)

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

// Drive playback events into the ping-pong buffer controller, predict every
// reply from a behavioural copy of the buffer state, and compare each reply
// field by field in arrival order.
module testbench;

  localparam int HALF_BYTES     = 32768;
  localparam int UNDERRUN_LIMIT = 2;
  // Quiet cycles (nothing accepted on either side) before the run is abandoned.
  localparam int QUIET_LIMIT    = 5000;

  logic           clk       = 1'b0;
  logic           rst       = 1'b1;
  logic           cfg_we    = 1'b0;
  logic           cfg_wdata = 1'b0;
  logic           req_valid = 1'b0;
  logic           req_stall;
  ppbc_pkg::req_t req       = '0;
  logic           rsp_valid;
  logic           rsp_stall = 1'b0;
  ppbc_pkg::rsp_t rsp;

  ping_pong_playback_buffer_control i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Predicted buffer state and register copy.
  logic        dev_present   = 1'b0;
  logic        buf_playing   = 1'b0;
  logic        buf_primed    = 1'b0;
  logic [1:0]  buf_full      = 2'b00;
  logic        buf_play_half = 1'b0;
  logic        buf_next      = 1'b0;
  logic [1:0]  buf_underruns = 2'd0;
  logic [15:0] buf_rate      = 16'd0;

  ppbc_pkg::rsp_t expected_replies[$];
  int   mismatches   = 0;
  int   tx_idle_pct  = 0;
  int   rx_idle_pct  = 0;
  int   hold_request = 0;
  int   hold_left    = 0;
  int   quiet_cycles = 0;

  function automatic void halt_stream();
    buf_playing   = 1'b0;
    buf_primed    = 1'b0;
    buf_full      = 2'b00;
    buf_underruns = 2'd0;
  endfunction

  function automatic void start_stream();
    buf_full[1]   = 1'b1;
    buf_next      = 1'b0;
    buf_primed    = 1'b0;
    buf_playing   = 1'b1;
    buf_play_half = 1'b0;
    buf_underruns = 2'd0;
  endfunction

  // Advance the predicted buffer state by one event and return its reply.
  function automatic ppbc_pkg::rsp_t apply_event(ppbc_pkg::req_t ev);
    ppbc_pkg::rsp_t r;
    logic [15:0]    rate;
    int             bytes;
    logic           wrote;
    logic           done_half;
    r     = '0;
    wrote = 1'b0;
    case (ev.cmd)
      ppbc_pkg::CMD_SUBMIT: begin
        if (!dev_present) begin
          r.status = ppbc_pkg::ST_NO_DEVICE;
        end else if (ev.byte_count == 16'd0) begin
          r.status = ppbc_pkg::ST_EMPTY;
        end else begin
          rate = ev.rate_hz;
          if (rate < ppbc_pkg::RATE_MIN) rate = ppbc_pkg::RATE_MIN;
          if (rate > ppbc_pkg::RATE_MAX) rate = ppbc_pkg::RATE_MAX;
          bytes = (int'(ev.byte_count) > HALF_BYTES) ? HALF_BYTES : int'(ev.byte_count);
          // A new rate tears the running stream down before anything else.
          if (buf_playing && buf_rate != rate) begin
            halt_stream();
            r.halted = 1'b1;
          end
          if (!buf_playing && !buf_primed) begin
            buf_full   = 2'b01;
            buf_next   = 1'b1;
            buf_rate   = rate;
            buf_primed = 1'b1;
            wrote      = 1'b1;
          end else if (buf_primed && !buf_playing) begin
            // Second submit: start at the rate stored by the prime.
            r.write_half   = 1'b1;
            wrote          = 1'b1;
            start_stream();
            r.stream_start = 1'b1;
          end else if (buf_full[buf_next]) begin
            r.status = ppbc_pkg::ST_BUSY;
          end else begin
            r.write_half       = buf_next;
            buf_full[buf_next] = 1'b1;
            buf_next           = ~buf_next;
            buf_underruns      = 2'd0;
            wrote              = 1'b1;
          end
          if (wrote) r.pad_count = 15'(HALF_BYTES - bytes);
        end
      end
      ppbc_pkg::CMD_HALF_DONE: begin
        if (buf_playing) begin
          done_half           = buf_play_half;
          buf_full[done_half] = 1'b0;
          buf_play_half       = ~done_half;
          buf_next            = done_half;
          if (!buf_full[buf_play_half]) begin
            // Underrun: the half now playing is refilled with silence.
            r.silence_fill          = 1'b1;
            r.silent_half           = buf_play_half;
            buf_full[buf_play_half] = 1'b1;
            if (buf_underruns < 2'd3) buf_underruns = buf_underruns + 2'd1;
            if (buf_underruns >= UNDERRUN_LIMIT) begin
              halt_stream();
              r.halted = 1'b1;
            end
          end else begin
            buf_underruns = 2'd0;
          end
        end
      end
      ppbc_pkg::CMD_STOP: begin
        if (dev_present) begin
          halt_stream();
          r.halted = 1'b1;
        end
      end
      ppbc_pkg::CMD_POLL: begin
        if (buf_primed && !buf_playing) begin
          start_stream();
          r.stream_start = 1'b1;
        end
      end
      default: ;
    endcase
    r.start_rate = buf_rate;
    r.is_playing = buf_playing;
    if (!dev_present) r.can_queue = 1'b0;
    else if (!buf_playing) r.can_queue = 1'b1;
    else r.can_queue = ~buf_full[buf_next];
    return r;
  endfunction

  function automatic int check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Reply checker: every accepted reply is matched against the oldest prediction.
  always @(posedge clk) begin
    ppbc_pkg::rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_replies.size() == 0) begin
        $display("%0t: reply with none pending, expected nothing, got %p", $time, rsp);
        mismatches++;
      end else begin
        want = expected_replies.pop_front();
        mismatches += check_field("status", want.status, rsp.status);
        mismatches += check_field("write_half", want.write_half, rsp.write_half);
        mismatches += check_field("pad_count", want.pad_count, rsp.pad_count);
        mismatches += check_field("silence_fill", want.silence_fill, rsp.silence_fill);
        mismatches += check_field("silent_half", want.silent_half, rsp.silent_half);
        mismatches += check_field("stream_start", want.stream_start, rsp.stream_start);
        mismatches += check_field("start_rate", want.start_rate, rsp.start_rate);
        mismatches += check_field("halted", want.halted, rsp.halted);
        mismatches += check_field("is_playing", want.is_playing, rsp.is_playing);
        mismatches += check_field("can_queue", want.can_queue, rsp.can_queue);
      end
    end
  end

  // Reply-side back-pressure: random stalls, or a long hold-off when requested.
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Watchdog: abandon the run if neither side moves for too long.
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Offer one event, hold it until accepted, then record its predicted reply.
  // Valid stays high afterwards so back-to-back items need not drop valid in between.
  task automatic send_event(ppbc_pkg::cmd_t c, logic [15:0] bytes, logic [15:0] rate);
    ppbc_pkg::req_t ev;
    ev = '{cmd: c, byte_count: bytes, rate_hz: rate};
    while ($urandom_range(99) < tx_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= ev;
    do @(posedge clk); while (req_stall);
    expected_replies.push_back(apply_event(ev));
  endtask

  // Drop valid and let every outstanding reply come back.
  task automatic wait_idle();
    req_valid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_device(logic present);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= present;
    @(posedge clk);
    cfg_we      <= 1'b0;
    dev_present = present;
  endtask

  // Without a card every submit is refused and a stop does nothing.
  task automatic test_no_device();
    set_device(1'b0);
    send_event(ppbc_pkg::CMD_SUBMIT, 16'd512, 16'd22050);
    send_event(ppbc_pkg::CMD_SUBMIT, 16'd0, 16'd0);
    send_event(ppbc_pkg::CMD_STOP, 16'd0, 16'd0);
    send_event(ppbc_pkg::CMD_HALF_DONE, 16'hFFFF, 16'hFFFF);
    send_event(ppbc_pkg::CMD_POLL, 16'd1, 16'd1);
    send_event(ppbc_pkg::CMD_SUBMIT, 16'hFFFF, 16'hFFFF);
  endtask

  // Walk the stream through priming, start, refill, underrun and every halt path.
  task automatic test_directed();
    set_device(1'b1);
    send_event(ppbc_pkg::CMD_SUBMIT, 16'd0, 16'd8000);       // empty submit
    send_event(ppbc_pkg::CMD_SUBMIT, 16'd1, 16'd0);          // prime, rate lifted to floor
    send_event(ppbc_pkg::CMD_POLL, 16'd0, 16'd0);            // poll starts primed stream
    send_event(ppbc_pkg::CMD_SUBMIT, 16'hFFFF, 16'hFFFF);    // rate change halts, reprimes
    send_event(ppbc_pkg::CMD_SUBMIT, 16'd32768, 16'd1000);   // start at stored rate
    send_event(ppbc_pkg::CMD_SUBMIT, 16'd100, 16'd44100);    // both halves busy
    send_event(ppbc_pkg::CMD_HALF_DONE, 16'd0, 16'd0);
    send_event(ppbc_pkg::CMD_SUBMIT, 16'd32767, 16'd44100);  // refill half 0
    send_event(ppbc_pkg::CMD_HALF_DONE, 16'd0, 16'd0);
    send_event(ppbc_pkg::CMD_HALF_DONE, 16'd0, 16'd0);       // first underrun
    send_event(ppbc_pkg::CMD_HALF_DONE, 16'd0, 16'd0);       // second underrun halts
    send_event(ppbc_pkg::CMD_HALF_DONE, 16'd0, 16'd0);       // idle, ignored
    send_event(ppbc_pkg::CMD_STOP, 16'd0, 16'd0);            // stop while idle still halts
    send_event(ppbc_pkg::CMD_POLL, 16'd0, 16'd0);            // nothing primed
    send_event(ppbc_pkg::CMD_SUBMIT, 16'd32769, 16'd3999);
    send_event(ppbc_pkg::CMD_SUBMIT, 16'd2, 16'd4000);
    send_event(ppbc_pkg::CMD_POLL, 16'd0, 16'd0);            // playing, no effect
    send_event(ppbc_pkg::CMD_STOP, 16'd0, 16'd0);            // stop while playing
    send_event(ppbc_pkg::CMD_SUBMIT, 16'd256, 16'd44101);    // rate capped at ceiling
    send_event(ppbc_pkg::CMD_SUBMIT, 16'd256, 16'd44100);
    send_event(ppbc_pkg::CMD_HALF_DONE, 16'd0, 16'd0);
    send_event(ppbc_pkg::CMD_HALF_DONE, 16'd0, 16'd0);
  endtask

  // Mostly playback sessions at one rate with random sizes; rare rate jumps,
  // stops and junk sizes break the sequences up.
  task automatic run_random_traffic(int count, int tx_pct, int rx_pct);
    logic [15:0] session_rate;
    tx_idle_pct  = tx_pct;
    rx_idle_pct  = rx_pct;
    session_rate = 16'd22050;
    for (int i = 0; i < count; i++) begin
      int             roll;
      ppbc_pkg::cmd_t c;
      logic [15:0]    bytes;
      logic [15:0]    rate;
      roll = $urandom_range(99);
      if (roll < 3) begin
        session_rate = 16'($urandom);
      end else if (roll < 6) begin
        case ($urandom_range(5))
          0: session_rate = 16'd0;
          1: session_rate = 16'd3999;
          2: session_rate = 16'd4000;
          3: session_rate = 16'd44100;
          4: session_rate = 16'd44101;
          default: session_rate = 16'hFFFF;
        endcase
      end
      roll = $urandom_range(99);
      if (roll < 46) c = ppbc_pkg::CMD_SUBMIT;
      else if (roll < 86) c = ppbc_pkg::CMD_HALF_DONE;
      else if (roll < 93) c = ppbc_pkg::CMD_POLL;
      else c = ppbc_pkg::CMD_STOP;
      roll = $urandom_range(99);
      if (roll < 3) bytes = 16'd0;
      else if (roll < 13) bytes = 16'($urandom);
      else if (roll < 20) bytes = 16'($urandom_range(65535, HALF_BYTES));
      else bytes = 16'($urandom_range(HALF_BYTES, 1));
      rate = ($urandom_range(99) < 8) ? 16'($urandom) : session_rate;
      send_event(c, bytes, rate);
    end
  endtask

  // Hold the reply side off for a long stretch while items keep coming, so
  // the block fills and stalls its request side.
  task automatic test_backpressure();
    tx_idle_pct  = 0;
    rx_idle_pct  = 0;
    hold_request = 300;
    run_random_traffic(40, 0, 0);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_no_device();
    test_directed();
    test_backpressure();
    run_random_traffic(500, 22, 60);
    set_device(1'b0);
    run_random_traffic(40, 22, 60);
    set_device(1'b1);
    run_random_traffic(500, 60, 22);
    set_device(1'b1);
    run_random_traffic(450, 0, 0);
    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/ppbc_pkg.sv
hdl/ping_pong_playback_buffer_control.sv
sim/testbench.sv
